### design/battery_filter_and_state_classifier_macros.svh
// Assertion macros for the battery filter and state classifier checker.
// Each macro assumes a clock named i_clk and an active-low reset i_rst_n.
// No dependencies.
`ifndef BATTERY_FILTER_AND_STATE_CLASSIFIER_MACROS_SVH
`define BATTERY_FILTER_AND_STATE_CLASSIFIER_MACROS_SVH

// Same-cycle implication
`define BFSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BFSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bfsc_pkg.sv
// Shared types, widths and constants of the battery filter and state classifier.
// No dependencies; every other design file imports this package.
package bfsc_pkg;

    // Field widths
    localparam int SMP_W    = 12;               // converter sample bits
    localparam int Q        = 8;                // fraction bits of the filters
    localparam int VAL_W    = SMP_W + Q;        // Q8 filtered value
    localparam int WIN_BITS = 3;                // log2 of window depth, at least 1
    localparam int WIN_DEPTH = 1 << WIN_BITS;
    localparam int SUM_W    = VAL_W + WIN_BITS; // running window sum
    localparam int ALPHA_W  = 9;
    localparam int PCT_W    = 7;
    localparam int ST_W     = 3;
    localparam int CNT_W    = 32;
    localparam int ACC_W    = ALPHA_W + VAL_W;  // multiply-accumulate width
    localparam int NUM_W    = VAL_W + PCT_W;    // percent dividend
    localparam int DIV_CNT_W = $clog2(PCT_W + 1);
    localparam int CFG_IDX_W = 3;

    // Arithmetic constants
    localparam logic [ALPHA_W-1:0] ONE_Q8    = ALPHA_W'(256);
    localparam logic [ACC_W-1:0]   HALF_Q8   = ACC_W'(128);
    localparam logic [ALPHA_W-1:0] PCT_SCALE = ALPHA_W'(100);
    localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);

    // Configuration reset values
    localparam logic [ALPHA_W-1:0] RST_ALPHA     = ALPHA_W'(64);
    localparam logic [VAL_W-1:0]   RST_EMPTY     = VAL_W'(0);
    localparam logic [VAL_W-1:0]   RST_FULL_LVL  = VAL_W'(1048320);
    localparam logic [VAL_W-1:0]   RST_CHG_ON    = VAL_W'(0);
    localparam logic [VAL_W-1:0]   RST_CHG_HYS   = VAL_W'(2560);
    localparam logic [PCT_W-1:0]   RST_FULL_PCT  = PCT_W'(95);
    localparam logic [PCT_W-1:0]   RST_LOW_PCT   = PCT_W'(20);
    localparam logic [PCT_W-1:0]   RST_CRIT_PCT  = PCT_W'(10);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA     = 3'd0,
        CFG_EMPTY     = 3'd1,
        CFG_FULL_LVL  = 3'd2,
        CFG_CHG_ON    = 3'd3,
        CFG_CHG_HYS   = 3'd4,
        CFG_FULL_PCT  = 3'd5,
        CFG_LOW_PCT   = 3'd6,
        CFG_CRIT_PCT  = 3'd7
    } t_cfg_idx;

    // Battery classes
    typedef enum logic [ST_W-1:0] {
        BST_OK       = 3'd0,
        BST_LOW      = 3'd1,
        BST_CRITICAL = 3'd2,
        BST_CHARGING = 3'd3,
        BST_FULL     = 3'd4
    } t_bstate;

    // Shared multiply-accumulate operations
    typedef enum logic [1:0] {
        MAC_HOLD = 2'd0,
        MAC_LOAD = 2'd1,
        MAC_ACC  = 2'd2
    } t_mac_op;

    typedef struct packed {
        logic [ALPHA_W-1:0] ema_alpha;
        logic [VAL_W-1:0]   volt_empty_level;
        logic [VAL_W-1:0]   volt_full_level;
        logic [VAL_W-1:0]   charge_on_level;
        logic [VAL_W-1:0]   charge_hysteresis;
        logic [PCT_W-1:0]   full_percent;
        logic [PCT_W-1:0]   low_percent;
        logic [PCT_W-1:0]   critical_percent;
    } t_cfg;

    typedef struct packed {
        logic [SMP_W-1:0] volt_sample;
        logic [SMP_W-1:0] curr_sample;
        logic             charger_present;
    } t_item;

    typedef struct packed {
        logic [VAL_W-1:0] filtered_voltage;
        logic [VAL_W-1:0] filtered_current;
        logic [PCT_W-1:0] charge_percent;
        logic             is_charging;
        logic [ST_W-1:0]  battery_state;
        logic             state_changed;
        logic [CNT_W-1:0] tick_count;
    } t_result;

    typedef struct packed {
        t_mac_op            op;
        logic [ALPHA_W-1:0] a;
        logic [VAL_W-1:0]   b;
        logic [ACC_W-1:0]   c;
    } t_mac_req;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [VAL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quo;
    } t_div_rsp;

endpackage

### design/bfsc_if.sv
// Valid/ready channel interfaces for tick inputs and classifier results.
// Depends on bfsc_pkg.
interface bfsc_in_if
    import bfsc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] volt_sample;
    logic [SMP_W-1:0] curr_sample;
    logic             charger_present;

    modport source (output valid, output volt_sample, output curr_sample,
                    output charger_present, input ready);
    modport sink   (input valid, input volt_sample, input curr_sample,
                    input charger_present, output ready);
endinterface

interface bfsc_out_if
    import bfsc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] filtered_voltage;
    logic [VAL_W-1:0] filtered_current;
    logic [PCT_W-1:0] charge_percent;
    logic             is_charging;
    logic [ST_W-1:0]  battery_state;
    logic             state_changed;
    logic [CNT_W-1:0] tick_count;

    modport source (output valid, output filtered_voltage, output filtered_current,
                    output charge_percent, output is_charging, output battery_state,
                    output state_changed, output tick_count, input ready);
    modport sink   (input valid, input filtered_voltage, input filtered_current,
                    input charge_percent, input is_charging, input battery_state,
                    input state_changed, input tick_count, output ready);
endinterface

### design/bfsc_mac.sv
// Shared multiply-accumulate unit: one 9x20 multiplier feeding an accumulator.
// Depends on bfsc_pkg.
module bfsc_mac
    import bfsc_pkg::*;
(
    input  logic             i_clk,
    input  t_mac_req         i_req,
    output logic [ACC_W-1:0] o_acc
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] w_prod;

    // Product, zero-extended to accumulator width
    assign w_prod = {{VAL_W{1'b0}}, i_req.a} * {{ALPHA_W{1'b0}}, i_req.b};

    // Load starts a new sum, accumulate adds to it
    always_ff @(posedge i_clk) begin
        case (i_req.op)
            MAC_LOAD: r_acc <= w_prod + i_req.c;
            MAC_ACC:  r_acc <= r_acc + w_prod;
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

### design/bfsc_div.sv
// Restoring serial divider for the state-of-charge percent, one quotient bit a cycle.
// Depends on bfsc_pkg.
module bfsc_div
    import bfsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_dsh;
    logic [PCT_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 w_ge;

    // Trial subtract of the shifted divisor
    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num;
                r_dsh  <= NUM_W'({i_req.den, {(PCT_W-1){1'b0}}});
                r_quo  <= '0;
                r_cnt  <= DIV_CNT_W'(PCT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quo <= {r_quo[PCT_W-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### design/bfsc_core.sv
// Sequencer, filter state, window memories and classifier of the battery monitor.
// Depends on bfsc_pkg; drives the shared bfsc_mac and bfsc_div units.
module bfsc_core
    import bfsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_item            i_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_result,
    output t_mac_req         o_mac_req,
    input  logic [ACC_W-1:0] i_mac_acc,
    output t_div_req         o_div_req,
    input  t_div_rsp         i_div_rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_EV1, S_EV2, S_EC1, S_EC2, S_WIN, S_PCT, S_DGO, S_DIV, S_CLASS
    } t_seq;

    t_seq                r_state;
    logic                r_seeded;
    logic                r_seed_item;
    logic                r_pin;
    logic [VAL_W-1:0]    r_xv;
    logic [VAL_W-1:0]    r_xc;
    logic [VAL_W-1:0]    r_avg_v;
    logic [VAL_W-1:0]    r_avg_c;
    logic [SUM_W-1:0]    r_sum_v;
    logic [SUM_W-1:0]    r_sum_c;
    logic [WIN_BITS-1:0] r_slot;
    logic [WIN_BITS-1:0] r_cnt;
    logic [VAL_W-1:0]    r_old_v;
    logic [VAL_W-1:0]    r_old_c;
    logic [VAL_W-1:0]    r_fv;
    logic [VAL_W-1:0]    r_fc;
    logic [PCT_W-1:0]    r_pct;
    logic                r_chg;
    t_bstate             r_prev;
    logic [CNT_W-1:0]    r_tick;
    logic                r_out_valid;
    t_result             r_result;

    logic [VAL_W-1:0]    r_mem_v [WIN_DEPTH];
    logic [VAL_W-1:0]    r_mem_c [WIN_DEPTH];

    logic                w_accept;
    logic                w_load;
    logic [WIN_BITS-1:0] w_nslot;
    logic [ALPHA_W-1:0]  w_alpha_sat;
    logic [ALPHA_W-1:0]  w_alpha_inv;
    logic [VAL_W-1:0]    w_ema;
    logic [SUM_W-1:0]    n_sum_v;
    logic [SUM_W-1:0]    n_sum_c;
    logic [VAL_W:0]      w_span;
    logic                w_pct_zero;
    logic                w_pct_full;
    logic [VAL_W:0]      w_chg_off;
    logic                w_chg_hys;
    logic                w_chg;
    t_bstate             w_st;
    logic [CNT_W-1:0]    w_tick;
    logic                w_mv_we;
    logic                w_mc_we;
    logic [WIN_BITS-1:0] w_mv_addr;
    logic [WIN_BITS-1:0] w_mc_addr;
    logic [VAL_W-1:0]    w_mv_data;
    logic [VAL_W-1:0]    w_mc_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = (r_state == S_CLASS) && (!r_out_valid || i_out_ready);
    assign w_nslot     = r_slot + 1'b1;

    // Alpha saturates at 1.0
    assign w_alpha_sat = (i_cfg.ema_alpha > ONE_Q8) ? ONE_Q8 : i_cfg.ema_alpha;
    assign w_alpha_inv = ONE_Q8 - w_alpha_sat;
    assign w_ema       = i_mac_acc[Q+VAL_W-1:Q];

    // Running window sums: drop the overwritten slot, add the new average
    assign n_sum_v = r_sum_v - SUM_W'(r_old_v) + SUM_W'(w_ema);
    assign n_sum_c = r_sum_c - SUM_W'(r_old_c) + SUM_W'(w_ema);

    // Percent range checks
    assign w_span     = {1'b0, i_cfg.volt_full_level} - {1'b0, i_cfg.volt_empty_level};
    assign w_pct_zero = w_span[VAL_W] || (w_span == '0) || (r_fv <= i_cfg.volt_empty_level);
    assign w_pct_full = (r_fv >= i_cfg.volt_full_level);

    // Charging hysteresis, pin override; forced off on the seeding tick
    assign w_chg_off = {1'b0, i_cfg.charge_on_level} + {1'b0, i_cfg.charge_hysteresis};
    assign w_chg_hys = r_chg ? ({1'b0, r_fc} <= w_chg_off) : (r_fc <= i_cfg.charge_on_level);
    assign w_chg     = !r_seed_item && (w_chg_hys || r_pin);
    assign w_tick    = r_seed_item ? '0 : r_tick + 1'b1;

    // Classification
    always_comb begin
        if (r_seed_item) begin
            w_st = BST_OK;
        end else if (w_chg && (r_pct >= i_cfg.full_percent)) begin
            w_st = BST_FULL;
        end else if (w_chg) begin
            w_st = BST_CHARGING;
        end else if (r_pct < i_cfg.critical_percent) begin
            w_st = BST_CRITICAL;
        end else if (r_pct < i_cfg.low_percent) begin
            w_st = BST_LOW;
        end else begin
            w_st = BST_OK;
        end
    end

    // Shared unit requests
    always_comb begin
        o_mac_req.op = MAC_HOLD;
        o_mac_req.a  = '0;
        o_mac_req.b  = '0;
        o_mac_req.c  = '0;
        case (r_state)
            S_EV1: begin
                o_mac_req.op = MAC_LOAD;
                o_mac_req.a  = w_alpha_sat;
                o_mac_req.b  = r_xv;
                o_mac_req.c  = HALF_Q8;
            end
            S_EV2: begin
                o_mac_req.op = MAC_ACC;
                o_mac_req.a  = w_alpha_inv;
                o_mac_req.b  = r_avg_v;
            end
            S_EC1: begin
                o_mac_req.op = MAC_LOAD;
                o_mac_req.a  = w_alpha_sat;
                o_mac_req.b  = r_xc;
                o_mac_req.c  = HALF_Q8;
            end
            S_EC2: begin
                o_mac_req.op = MAC_ACC;
                o_mac_req.a  = w_alpha_inv;
                o_mac_req.b  = r_avg_c;
            end
            S_PCT: begin
                o_mac_req.op = MAC_LOAD;
                o_mac_req.a  = PCT_SCALE;
                o_mac_req.b  = r_fv - i_cfg.volt_empty_level;
            end
            default: begin
                o_mac_req.op = MAC_HOLD;
            end
        endcase
    end

    assign o_div_req.start = (r_state == S_DGO);
    assign o_div_req.num   = i_mac_acc[NUM_W-1:0];
    assign o_div_req.den   = w_span[VAL_W-1:0];

    // Window memory write ports: seeding sweep or the advanced slot
    assign w_mv_we   = (r_state == S_SEED) || (r_state == S_EC1);
    assign w_mc_we   = (r_state == S_SEED) || (r_state == S_WIN);
    assign w_mv_addr = (r_state == S_SEED) ? r_cnt : w_nslot;
    assign w_mc_addr = (r_state == S_SEED) ? r_cnt : w_nslot;
    assign w_mv_data = (r_state == S_SEED) ? r_xv : w_ema;
    assign w_mc_data = (r_state == S_SEED) ? r_xc : w_ema;

    always_ff @(posedge i_clk) begin
        if (w_mv_we) begin
            r_mem_v[w_mv_addr] <= w_mv_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mc_we) begin
            r_mem_c[w_mc_addr] <= w_mc_data;
        end
    end

    // Registered read of the slot about to be overwritten
    always_ff @(posedge i_clk) begin
        if (r_state == S_EV1) begin
            r_old_v <= r_mem_v[w_nslot];
            r_old_c <= r_mem_c[w_nslot];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_slot      <= '0;
            r_chg       <= 1'b0;
            r_prev      <= BST_OK;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_xv        <= {i_item.volt_sample, {Q{1'b0}}};
                        r_xc        <= {i_item.curr_sample, {Q{1'b0}}};
                        r_pin       <= i_item.charger_present;
                        r_seed_item <= !r_seeded;
                        r_cnt       <= '0;
                        r_state     <= r_seeded ? S_EV1 : S_SEED;
                    end
                end
                S_SEED: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == WIN_BITS'(WIN_DEPTH - 1)) begin
                        r_avg_v  <= r_xv;
                        r_avg_c  <= r_xc;
                        r_sum_v  <= {r_xv, {WIN_BITS{1'b0}}};
                        r_sum_c  <= {r_xc, {WIN_BITS{1'b0}}};
                        r_slot   <= '0;
                        r_fv     <= r_xv;
                        r_fc     <= r_xc;
                        r_seeded <= 1'b1;
                        r_state  <= S_PCT;
                    end
                end
                S_EV1: begin
                    r_state <= S_EV2;
                end
                S_EV2: begin
                    r_state <= S_EC1;
                end
                S_EC1: begin
                    r_avg_v <= w_ema;
                    r_sum_v <= n_sum_v;
                    r_state <= S_EC2;
                end
                S_EC2: begin
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    r_avg_c <= w_ema;
                    r_sum_c <= n_sum_c;
                    r_slot  <= w_nslot;
                    r_fv    <= r_sum_v[SUM_W-1:WIN_BITS];
                    r_fc    <= n_sum_c[SUM_W-1:WIN_BITS];
                    r_state <= S_PCT;
                end
                S_PCT: begin
                    if (w_pct_zero) begin
                        r_pct   <= '0;
                        r_state <= S_CLASS;
                    end else if (w_pct_full) begin
                        r_pct   <= PCT_FULL;
                        r_state <= S_CLASS;
                    end else begin
                        r_state <= S_DGO;
                    end
                end
                S_DGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_pct   <= i_div_rsp.quo;
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    if (w_load) begin
                        r_result.filtered_voltage <= r_fv;
                        r_result.filtered_current <= r_fc;
                        r_result.charge_percent   <= r_pct;
                        r_result.is_charging      <= w_chg;
                        r_result.battery_state    <= w_st;
                        r_result.state_changed    <= !r_seed_item && (w_st != r_prev);
                        r_result.tick_count       <= w_tick;
                        r_chg   <= w_chg;
                        r_prev  <= w_st;
                        r_tick  <= w_tick;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### design/battery_filter_and_state_classifier.sv
// Top level of the battery monitor: configuration registers, channels, shared units.
// Depends on bfsc_pkg, bfsc_if, bfsc_mac, bfsc_div and bfsc_core.
//
//  Channel   Direction  Transfer when          Carries
//  i_in_ch   sink       valid && ready         volt_sample, curr_sample, charger_present
//  o_out_ch  source     valid && ready         filtered levels, percent, class, tick count
//  i_cfg_*   write      i_cfg_we high          register index and data, no read-back
//
//  A normal tick runs from its transfer back to ready through idle, four filter steps,
//  window update, percent check and class, and also through the serial divider when the
//  percent needs it (start, the seven-bit quotient, hand-over).
//  The first tick after reset sweeps both 8-entry windows, one slot a cycle.
//  Input ready is high only while the sequencer waits for a tick; a result held in
//  the output register stalls the next one in its final step until it is taken.
//  Synchronous reset restores the register defaults and the unseeded state.
module battery_filter_and_state_classifier
    import bfsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bfsc_in_if.sink              i_in_ch,
    bfsc_out_if.source           o_out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    t_cfg             r_cfg;
    t_item            w_item;
    t_result          w_result;
    t_mac_req         w_mac_req;
    logic [ACC_W-1:0] w_mac_acc;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;
    logic             w_in_ready;
    logic             w_out_valid;

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ema_alpha         <= RST_ALPHA;
            r_cfg.volt_empty_level  <= RST_EMPTY;
            r_cfg.volt_full_level   <= RST_FULL_LVL;
            r_cfg.charge_on_level   <= RST_CHG_ON;
            r_cfg.charge_hysteresis <= RST_CHG_HYS;
            r_cfg.full_percent      <= RST_FULL_PCT;
            r_cfg.low_percent       <= RST_LOW_PCT;
            r_cfg.critical_percent  <= RST_CRIT_PCT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHA:    r_cfg.ema_alpha         <= i_cfg_data[ALPHA_W-1:0];
                CFG_EMPTY:    r_cfg.volt_empty_level  <= i_cfg_data;
                CFG_FULL_LVL: r_cfg.volt_full_level   <= i_cfg_data;
                CFG_CHG_ON:   r_cfg.charge_on_level   <= i_cfg_data;
                CFG_CHG_HYS:  r_cfg.charge_hysteresis <= i_cfg_data;
                CFG_FULL_PCT: r_cfg.full_percent      <= i_cfg_data[PCT_W-1:0];
                CFG_LOW_PCT:  r_cfg.low_percent       <= i_cfg_data[PCT_W-1:0];
                CFG_CRIT_PCT: r_cfg.critical_percent  <= i_cfg_data[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input channel unpacking
    assign w_item.volt_sample     = i_in_ch.volt_sample;
    assign w_item.curr_sample     = i_in_ch.curr_sample;
    assign w_item.charger_present = i_in_ch.charger_present;
    assign i_in_ch.ready          = w_in_ready;

    bfsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (w_in_ready),
        .i_item      (w_item),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out_ch.ready),
        .o_result    (w_result),
        .o_mac_req   (w_mac_req),
        .i_mac_acc   (w_mac_acc),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp)
    );

    bfsc_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_mac_req),
        .o_acc (w_mac_acc)
    );

    bfsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Output channel packing
    assign o_out_ch.valid            = w_out_valid;
    assign o_out_ch.filtered_voltage = w_result.filtered_voltage;
    assign o_out_ch.filtered_current = w_result.filtered_current;
    assign o_out_ch.charge_percent   = w_result.charge_percent;
    assign o_out_ch.is_charging      = w_result.is_charging;
    assign o_out_ch.battery_state    = w_result.battery_state;
    assign o_out_ch.state_changed    = w_result.state_changed;
    assign o_out_ch.tick_count       = w_result.tick_count;

endmodule

### design/bfsc_checker.sv
// Port-level checker for the battery monitor, bound to the top level.
// Depends on bfsc_pkg and battery_filter_and_state_classifier_macros.svh.
`include "battery_filter_and_state_classifier_macros.svh"

module bfsc_checker
    import bfsc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [VAL_W-1:0] i_fv,
    input logic [VAL_W-1:0] i_fc,
    input logic [PCT_W-1:0] i_pct,
    input logic             i_chg,
    input logic [ST_W-1:0]  i_st,
    input logic             i_changed,
    input logic [CNT_W-1:0] i_tick
);

    logic w_in_xfer;
    logic w_stall;
    logic w_chg_class;
    logic [2*VAL_W+PCT_W+ST_W+CNT_W+1:0] w_payload;

    assign w_in_xfer   = i_in_valid && i_in_ready;
    assign w_stall     = i_out_valid && !i_out_ready;
    assign w_chg_class = (i_st == BST_CHARGING) || (i_st == BST_FULL);
    assign w_payload   = {i_fv, i_fc, i_pct, i_chg, i_st, i_changed, i_tick};

    // A stalled result keeps its payload
    `BFSC_ASSERT_NXT(a_out_hold, w_stall, i_out_valid && $stable(w_payload), "result moved")
    // State of charge never passes full scale
    `BFSC_ASSERT_IMP(a_pct_range, i_out_valid, i_pct <= PCT_FULL, "percent above full")
    // Charging flag and charging classes agree
    `BFSC_ASSERT_IMP(a_chg_class, i_out_valid, i_chg == w_chg_class, "class/flag mismatch")
    // Input ready is low in the cycle after a tick transfer
    `BFSC_ASSERT_NXT(a_busy, w_in_xfer, !i_in_ready, "ready straight after transfer")

endmodule

bind battery_filter_and_state_classifier bfsc_checker u_bfsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_fv        (o_out_ch.filtered_voltage),
    .i_fc        (o_out_ch.filtered_current),
    .i_pct       (o_out_ch.charge_percent),
    .i_chg       (o_out_ch.is_charging),
    .i_st        (o_out_ch.battery_state),
    .i_changed   (o_out_ch.state_changed),
    .i_tick      (o_out_ch.tick_count)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for battery_filter_and_state_classifier: tick driver, reading monitor,
// bit-exact filter/percent/class predictor and register-write sequencing between phases.
// Depends on the design files: bfsc_pkg, bfsc_if and the top level with its submodules.
module testbench;
    import bfsc_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VAL_W-1:0]     i_cfg_data;

    bfsc_in_if  tick_ch ();
    bfsc_out_if reading_ch ();

    battery_filter_and_state_classifier i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (tick_ch),
        .o_out_ch   (reading_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Stimulus and scoreboard storage
    t_item   queued_ticks [$];
    t_result due_readings [$];
    t_item   tick_on_bus;
    int      ticks_issued;
    int      ticks_accepted;
    int      readings_seen;
    int      fault_count;
    int      idle_odds;     // 1 in idle_odds chance of a burst; 0 disables idling
    int      send_gap;
    int      hold_gap;

    // Predictor copy of the registers and the block state
    t_cfg             live_cfg;
    logic [VAL_W-1:0] volt_ema, curr_ema;
    logic [VAL_W-1:0] volt_hist [WIN_DEPTH];
    logic [VAL_W-1:0] curr_hist [WIN_DEPTH];
    logic [WIN_BITS-1:0] hist_slot;
    logic             chg_flag;
    t_bstate          last_class;
    logic             seeded;
    logic [CNT_W-1:0] ticks_done;

    // Clock, with every input held at a known level from time zero
    initial begin
        i_clk              = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_ALPHA;
        i_cfg_data         = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.volt_sample = '0;
        tick_ch.curr_sample = '0;
        tick_ch.charger_present = 1'b0;
        reading_ch.ready   = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // Q8 exponential average, weight saturated at 1.0, rounded half up
    function automatic logic [VAL_W-1:0] ema_next(logic [VAL_W-1:0] avg, logic [VAL_W-1:0] x);
        logic [ALPHA_W-1:0] w;
        logic [ACC_W:0]     acc;
        w   = (live_cfg.ema_alpha > 9'd256) ? 9'd256 : live_cfg.ema_alpha;
        acc = (ACC_W+1)'(w) * (ACC_W+1)'(x) + (ACC_W+1)'(9'd256 - w) * (ACC_W+1)'(avg)
            + (ACC_W+1)'(128);
        return acc[Q +: VAL_W];
    endfunction

    // State of charge: truncated, clamped, zero on an empty or inverted span
    function automatic logic [PCT_W-1:0] soc_percent(logic [VAL_W-1:0] v);
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        if (live_cfg.volt_full_level <= live_cfg.volt_empty_level) return '0;
        if (v <= live_cfg.volt_empty_level) return '0;
        if (v >= live_cfg.volt_full_level) return 7'd100;
        num = NUM_W'(v - live_cfg.volt_empty_level) * NUM_W'(100);
        den = NUM_W'(live_cfg.volt_full_level - live_cfg.volt_empty_level);
        return PCT_W'(num / den);
    endfunction

    // One monitor tick: filters, percent, charging hysteresis, class
    function automatic t_result classify_tick(t_item it);
        t_result          r;
        logic [VAL_W-1:0] xv, xc, fv, fc;
        logic [SUM_W-1:0] vsum, csum;
        logic [PCT_W-1:0] pct;
        t_bstate          cls;
        int               k;
        xv = {it.volt_sample, 8'h00};
        xc = {it.curr_sample, 8'h00};
        // first tick after reset fills both filters with the sample
        if (!seeded) begin
            volt_ema = xv;
            curr_ema = xc;
            for (k = 0; k < WIN_DEPTH; k++) begin
                volt_hist[k] = xv;
                curr_hist[k] = xc;
            end
            hist_slot  = '0;
            chg_flag   = 1'b0;
            last_class = BST_OK;
            ticks_done = '0;
            seeded     = 1'b1;
            r.filtered_voltage = xv;
            r.filtered_current = xc;
            r.charge_percent   = soc_percent(xv);
            r.is_charging      = 1'b0;
            r.battery_state    = BST_OK;
            r.state_changed    = 1'b0;
            r.tick_count       = '0;
            return r;
        end
        hist_slot = hist_slot + 1'b1;
        volt_ema  = ema_next(volt_ema, xv);
        curr_ema  = ema_next(curr_ema, xc);
        volt_hist[hist_slot] = volt_ema;
        curr_hist[hist_slot] = curr_ema;
        vsum = '0;
        csum = '0;
        for (k = 0; k < WIN_DEPTH; k++) begin
            vsum = vsum + SUM_W'(volt_hist[k]);
            csum = csum + SUM_W'(curr_hist[k]);
        end
        fv = vsum[SUM_W-1:WIN_BITS];
        fc = csum[SUM_W-1:WIN_BITS];
        ticks_done = ticks_done + 1'b1;
        pct = soc_percent(fv);
        // charging starts at or below the start level, stops above level plus margin
        if (!chg_flag) begin
            if (fc <= live_cfg.charge_on_level) chg_flag = 1'b1;
        end else if ({1'b0, fc} > {1'b0, live_cfg.charge_on_level}
                                  + {1'b0, live_cfg.charge_hysteresis}) begin
            chg_flag = 1'b0;
        end
        if (it.charger_present) chg_flag = 1'b1;
        if (chg_flag && pct >= live_cfg.full_percent) cls = BST_FULL;
        else if (chg_flag) cls = BST_CHARGING;
        else if (pct < live_cfg.critical_percent) cls = BST_CRITICAL;
        else if (pct < live_cfg.low_percent) cls = BST_LOW;
        else cls = BST_OK;
        r.filtered_voltage = fv;
        r.filtered_current = fc;
        r.charge_percent   = pct;
        r.is_charging      = chg_flag;
        r.battery_state    = cls;
        r.state_changed    = (cls != last_class);
        r.tick_count       = ticks_done;
        last_class = cls;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_fault(string msg);
        fault_count++;
        $display("ERROR: reading %0d: %s", readings_seen, msg);
    endtask

    task automatic compare_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        if (got !== want) flag_fault($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_reading();
        t_result want;
        if (due_readings.size() == 0) begin
            flag_fault($sformatf("reading with no tick pending, tick_count %0d",
                                 reading_ch.tick_count));
            return;
        end
        want = due_readings.pop_front();
        compare_field("filtered_voltage", CNT_W'(reading_ch.filtered_voltage),
                      CNT_W'(want.filtered_voltage));
        compare_field("filtered_current", CNT_W'(reading_ch.filtered_current),
                      CNT_W'(want.filtered_current));
        compare_field("charge_percent", CNT_W'(reading_ch.charge_percent),
                      CNT_W'(want.charge_percent));
        compare_field("is_charging", CNT_W'(reading_ch.is_charging),
                      CNT_W'(want.is_charging));
        compare_field("battery_state", CNT_W'(reading_ch.battery_state),
                      CNT_W'(want.battery_state));
        compare_field("state_changed", CNT_W'(reading_ch.state_changed),
                      CNT_W'(want.state_changed));
        compare_field("tick_count", reading_ch.tick_count, want.tick_count);
    endtask

    // ---------------------------------------------------------------- driver

    // Tick driver: predicts on each transfer, then loads the next tick or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
        end else begin
            if (tick_ch.valid && tick_ch.ready) begin
                due_readings.push_back(classify_tick(tick_on_bus));
                ticks_accepted++;
            end
            if (!tick_ch.valid || tick_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    tick_ch.valid <= 1'b0;
                end else if (idle_odds != 0 && queued_ticks.size() != 0
                             && $urandom_range(1, idle_odds) == 1) begin
                    send_gap = $urandom_range(0, 2);
                    tick_ch.valid <= 1'b0;
                end else if (queued_ticks.size() != 0) begin
                    tick_on_bus = queued_ticks.pop_front();
                    tick_ch.valid           <= 1'b1;
                    tick_ch.volt_sample     <= tick_on_bus.volt_sample;
                    tick_ch.curr_sample     <= tick_on_bus.curr_sample;
                    tick_ch.charger_present <= tick_on_bus.charger_present;
                end else begin
                    tick_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Reading monitor: checks each transfer, stalls in short random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reading_ch.ready <= 1'b0;
        end else begin
            if (reading_ch.valid && reading_ch.ready) begin
                check_reading();
                readings_seen++;
            end
            if (hold_gap > 0) begin
                hold_gap--;
                reading_ch.ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                hold_gap = $urandom_range(0, 2);
                reading_ch.ready <= 1'b0;
            end else begin
                reading_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_tick(logic [SMP_W-1:0] v, logic [SMP_W-1:0] c, logic pin);
        t_item it;
        it.volt_sample     = v;
        it.curr_sample     = c;
        it.charger_present = pin;
        queued_ticks.push_back(it);
        ticks_issued++;
    endtask

    // Wait until every tick is sent and read back and the block waits for a tick
    task automatic wait_all_readings();
        do @(posedge i_clk);
        while (ticks_accepted != ticks_issued || due_readings.size() != 0 || !tick_ch.ready);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [VAL_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Writes all eight registers; junk above the narrow registers must be dropped
    task automatic apply_setting(t_cfg s);
        write_reg(CFG_ALPHA, {11'($urandom), s.ema_alpha});
        write_reg(CFG_EMPTY, s.volt_empty_level);
        write_reg(CFG_FULL_LVL, s.volt_full_level);
        write_reg(CFG_CHG_ON, s.charge_on_level);
        write_reg(CFG_CHG_HYS, s.charge_hysteresis);
        write_reg(CFG_FULL_PCT, {13'($urandom), s.full_percent});
        write_reg(CFG_LOW_PCT, {13'($urandom), s.low_percent});
        write_reg(CFG_CRIT_PCT, {13'($urandom), s.critical_percent});
        i_cfg_we <= 1'b0;
        live_cfg = s;
    endtask

    function automatic t_cfg random_setting();
        t_cfg s;
        int   lo, hi;
        case ($urandom_range(0, 9))
            0:       s.ema_alpha = '0;
            1:       s.ema_alpha = 9'd256;
            2:       s.ema_alpha = 9'($urandom_range(257, 511));
            default: s.ema_alpha = 9'($urandom_range(8, 255));
        endcase
        lo = $urandom_range(0, 3000);
        hi = $urandom_range(lo + 1, 4095);
        s.volt_empty_level = {12'(lo), 8'($urandom)};
        s.volt_full_level  = {12'(hi), 8'($urandom)};
        // occasionally an inverted, full-scale or zero span
        case ($urandom_range(0, 9))
            0: {s.volt_empty_level, s.volt_full_level} = {s.volt_full_level, s.volt_empty_level};
            1: begin
                s.volt_empty_level = '0;
                s.volt_full_level  = '1;
            end
            2: s.volt_full_level = s.volt_empty_level;
            default: ;
        endcase
        s.charge_on_level   = {12'($urandom_range(0, 4095)), 8'($urandom)};
        s.charge_hysteresis = ($urandom_range(0, 9) == 0) ? '1
                            : {12'($urandom_range(0, 600)), 8'($urandom)};
        if ($urandom_range(0, 7) == 0) begin
            s.full_percent     = 7'($urandom);
            s.low_percent      = 7'($urandom);
            s.critical_percent = 7'($urandom);
        end else begin
            s.critical_percent = 7'($urandom_range(0, 30));
            s.low_percent      = s.critical_percent + 7'($urandom_range(0, 40));
            s.full_percent     = 7'($urandom_range(50, 100));
        end
        return s;
    endfunction

    function automatic logic [SMP_W-1:0] fit_count(int n);
        return (n < 0) ? '0 : (n > 4095) ? '1 : SMP_W'(n);
    endfunction

    // Held levels around the span and the charging levels that jump at random, with some raw noise
    task automatic queue_random_ticks(int count);
        int   v_lo, v_hi, c_mid, c_span, volt_aim, curr_aim, swap, n;
        logic pin;
        v_lo = int'(live_cfg.volt_empty_level >> Q);
        v_hi = int'(live_cfg.volt_full_level >> Q);
        if (v_lo > v_hi) begin
            swap = v_lo;
            v_lo = v_hi;
            v_hi = swap;
        end
        c_mid    = int'(live_cfg.charge_on_level >> Q);
        c_span   = int'(live_cfg.charge_hysteresis >> Q) + 32;
        pin      = 1'b0;
        volt_aim = v_hi;
        curr_aim = c_mid + c_span;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 11) == 0) begin
                volt_aim = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095))
                                                       : int'($urandom_range(v_lo, v_hi));
                curr_aim = c_mid - c_span + int'($urandom_range(0, 3 * c_span));
            end
            if ($urandom_range(0, 11) == 0) pin = !pin;
            if ($urandom_range(0, 5) == 0)
                queue_tick(12'($urandom), 12'($urandom), 1'($urandom));
            else
                queue_tick(fit_count(volt_aim + int'($urandom_range(0, 32)) - 16),
                           fit_count(curr_aim + int'($urandom_range(0, 32)) - 16), pin);
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int ph;
        ticks_issued   = 0;
        ticks_accepted = 0;
        readings_seen  = 0;
        fault_count    = 0;
        send_gap       = 0;
        hold_gap       = 0;
        idle_odds      = 5;
        seeded         = 1'b0;
        hist_slot      = '0;
        chg_flag       = 1'b0;
        last_class     = BST_OK;
        ticks_done     = '0;
        volt_ema       = '0;
        curr_ema       = '0;
        live_cfg = t_cfg'{9'd64, 20'd0, 20'd1048320, 20'd0, 20'd2560, 7'd95, 7'd20, 7'd10};

        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: seeding tick ignores the charger pin, then field extremes
        queue_tick(12'hFFF, 12'h000, 1'b1);
        queue_tick(12'h000, 12'hFFF, 1'b0);
        queue_tick(12'h000, 12'hFFF, 1'b0);
        queue_tick(12'hFFF, 12'h000, 1'b0);
        queue_tick(12'hAAA, 12'h555, 1'b1);
        queue_tick(12'h555, 12'hAAA, 1'b0);
        queue_tick(12'h000, 12'h000, 1'b0);
        wait_all_readings();

        // no smoothing, usable span: full, falling to low and critical, pin override
        apply_setting(t_cfg'{9'd256, 20'd256000, 20'd896000, 20'd128000, 20'd51200,
                             7'd95, 7'd20, 7'd10});
        repeat (4) queue_tick(12'hFFF, 12'h000, 1'b0);
        repeat (4) queue_tick(12'd1000, 12'hFFF, 1'b0);
        repeat (2) queue_tick(12'd2000, 12'hFFF, 1'b1);
        wait_all_readings();

        // alpha saturated, zero span, top levels and thresholds above a hundred
        apply_setting(t_cfg'{9'd511, 20'h80000, 20'h80000, 20'hFFFFF, 20'hFFFFF,
                             7'd127, 7'd127, 7'd127});
        queue_tick(12'hFFF, 12'hFFF, 1'b0);
        queue_tick(12'h000, 12'h000, 1'b0);
        queue_tick(12'h800, 12'h800, 1'b0);
        wait_all_readings();

        // frozen filters, inverted span, zero levels and thresholds
        apply_setting(t_cfg'{9'd0, 20'hFFFFF, 20'h00000, 20'h00000, 20'h00000,
                             7'd0, 7'd0, 7'd0});
        queue_tick(12'hFFF, 12'hFFF, 1'b0);
        queue_tick(12'h000, 12'h000, 1'b1);
        queue_tick(12'h123, 12'hEDC, 1'b0);
        wait_all_readings();

        // random phases; the sender holds off between them until all readings are in
        for (ph = 0; ph < 8; ph++) begin
            apply_setting(random_setting());
            case ($urandom_range(0, 2))
                0:       idle_odds = 3;
                1:       idle_odds = 8;
                default: idle_odds = 20;
            endcase
            if (ph == 7) idle_odds = 0;
            queue_random_ticks(86);
            wait_all_readings();
        end

        repeat (25) @(posedge i_clk);
        if (fault_count == 0 && due_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
